### hw/rtl/mrm_pkg.sv
// shared constants and types for the micro-op register machine
package mrm_pkg;

    // main memory geometry (depth may range from 64 to 256 bytes)
    localparam int MEM_DEPTH = 256;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);

    // writes below this address are refused by micro-op 14
    localparam logic [7:0] PROTECT_LIMIT = 8'd32;

    // stream payload widths
    localparam int S_DATA_W = 32;
    localparam int S_USER_W = 1;
    localparam int M_DATA_W = 32;
    localparam int M_USER_W = 3;

    // micro-operation codes
    localparam logic [4:0] UOP_MAR_PC    = 5'd1;
    localparam logic [4:0] UOP_PC_MDR    = 5'd2;
    localparam logic [4:0] UOP_ACC_MDR   = 5'd3;
    localparam logic [4:0] UOP_MDR_ACC   = 5'd4;
    localparam logic [4:0] UOP_OPC_MDR   = 5'd5;
    localparam logic [4:0] UOP_OPA_MDR   = 5'd6;
    localparam logic [4:0] UOP_MAR_OPA   = 5'd7;
    localparam logic [4:0] UOP_MDR_IN    = 5'd8;
    localparam logic [4:0] UOP_OUT_MDR   = 5'd9;
    localparam logic [4:0] UOP_SEL_ADD   = 5'd10;
    localparam logic [4:0] UOP_SEL_SUB   = 5'd11;
    localparam logic [4:0] UOP_ALU       = 5'd12;
    localparam logic [4:0] UOP_MEM_READ  = 5'd13;
    localparam logic [4:0] UOP_MEM_WRITE = 5'd14;
    localparam logic [4:0] UOP_PC_INC    = 5'd15;
    localparam logic [4:0] UOP_LATCH_IN  = 5'd16;
    localparam logic [4:0] UOP_SEL_NAND  = 5'd17;

    // result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_JUMP      = 2'd1;
    localparam logic [1:0] ST_PROTECTED = 2'd2;
    localparam logic [1:0] ST_INVALID   = 2'd3;

    // alu function select
    typedef enum logic [1:0] {
        ALU_ADD  = 2'd0,
        ALU_SUB  = 2'd1,
        ALU_NAND = 2'd2
    } alu_sel_t;

    // alu operation, unknown select acts as add
    function automatic logic [7:0] alu_apply(alu_sel_t sel, logic [7:0] x, logic [7:0] y);
        logic [7:0] r;
        case (sel)
            ALU_SUB:  r = x - y;
            ALU_NAND: r = ~(x & y);
            default:  r = x + y;
        endcase
        return r;
    endfunction

endpackage

### hw/rtl/mrm_ram.sv
// generic single-port-write, single-port-read ram with registered read data
module mrm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read, holds when not enabled
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

### hw/rtl/microop_register_machine.sv
// top level of the micro-op register machine with its byte memory
//
// channel | dir | beat contents (lowest bit first)
// s_*     | in  | tuser: mode; tdata: micro_op, load_address, load_data, in_value
// m_*     | out | tuser: status, out_valid; tdata: out_value, pc, acc, opcode
//
// one beat is accepted per cycle while s_tready is high, and each gives one registered result beat.
// micro-op 13 reads the memory port; its byte returns the next cycle and is
// forwarded to the following beat, so back-to-back reads and uses run at full rate.
// reset clears the architectural registers, read tracking, output valid flag and per-byte valid
// flags at once, so memory reads as zero until written; no clearing pass is needed.
// the input stalls only while a result waits in the output register and m_tready is low.
module microop_register_machine (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // micro_op[4:0], load_address[12:5], load_data[20:13],
                                   // in_value[28:21], zero[31:29]
    input  logic [0:0]  s_tuser,   // mode[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // out_value[7:0], pc_value[15:8], acc_value[23:16],
                                   // opcode_value[31:24]
    output logic [2:0]  m_tuser    // status[1:0], out_valid[2]
);

    // input fields
    logic       mode;
    logic [4:0] micro_op;
    logic [7:0] load_address;
    logic [7:0] load_data;
    logic [7:0] in_value;

    assign mode         = s_tuser[0];
    assign micro_op     = s_tdata[4:0];
    assign load_address = s_tdata[12:5];
    assign load_data    = s_tdata[20:13];
    assign in_value     = s_tdata[28:21];

    // architectural registers
    logic [7:0]        pc_reg, pc_next;
    logic [7:0]        mar_reg, mar_next;
    logic [7:0]        mdr_reg, mdr_next;
    logic [7:0]        acc_reg, acc_next;
    logic [7:0]        opc_reg, opc_next;
    logic [7:0]        opa_reg, opa_next;
    mrm_pkg::alu_sel_t alu_reg, alu_next;
    logic [7:0]        latch_reg, latch_next;

    // memory read tracking and per-byte valid flags
    logic                  rd_pend_reg;
    logic                  rd_ok_reg;
    logic                  mem_valid_reg [mrm_pkg::MEM_DEPTH];
    logic [7:0]            ram_rdata;
    logic                  ram_we;
    logic                  ram_re;
    logic [7:0]            wr_addr;
    logic [7:0]            wr_data;
    logic [mrm_pkg::MEM_AW-1:0] wr_idx;
    logic [mrm_pkg::MEM_AW-1:0] rd_idx;
    logic                  wr_in_range;
    logic                  rd_in_range;
    logic [7:0]            mdr_cur;

    // output register
    logic        m_valid_reg;
    logic [31:0] m_data_reg;
    logic [2:0]  m_user_reg;

    // result fields of the current beat
    logic [1:0] status;
    logic       out_valid;
    logic [7:0] out_value;

    logic s_accept;

    assign s_tready = !m_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    // memory data register with the pending read byte forwarded
    assign mdr_cur = rd_pend_reg ? (rd_ok_reg ? ram_rdata : 8'h00) : mdr_reg;

    // address decode against the memory depth
    assign wr_in_range = {1'b0, wr_addr} < 9'(mrm_pkg::MEM_DEPTH);
    assign rd_in_range = {1'b0, mar_reg} < 9'(mrm_pkg::MEM_DEPTH);
    assign wr_idx      = wr_addr[mrm_pkg::MEM_AW-1:0];
    assign rd_idx      = mar_reg[mrm_pkg::MEM_AW-1:0];

    // micro-op decode and register transfer
    always_comb begin
        pc_next    = pc_reg;
        mar_next   = mar_reg;
        mdr_next   = mdr_cur;
        acc_next   = acc_reg;
        opc_next   = opc_reg;
        opa_next   = opa_reg;
        alu_next   = alu_reg;
        latch_next = latch_reg;
        status     = mrm_pkg::ST_OK;
        out_valid  = 1'b0;
        out_value  = 8'h00;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        wr_addr    = mar_reg;
        wr_data    = mdr_cur;
        if (mode) begin
            wr_addr = load_address;
            wr_data = load_data;
            ram_we  = s_accept && wr_in_range;
        end else begin
            case (micro_op)
                mrm_pkg::UOP_MAR_PC:   mar_next = pc_reg;
                mrm_pkg::UOP_PC_MDR: begin
                    pc_next = mdr_cur;
                    status  = mrm_pkg::ST_JUMP;
                end
                mrm_pkg::UOP_ACC_MDR:  acc_next = mdr_cur;
                mrm_pkg::UOP_MDR_ACC:  mdr_next = acc_reg;
                mrm_pkg::UOP_OPC_MDR:  opc_next = mdr_cur;
                mrm_pkg::UOP_OPA_MDR:  opa_next = mdr_cur;
                mrm_pkg::UOP_MAR_OPA:  mar_next = opa_reg;
                mrm_pkg::UOP_MDR_IN:   mdr_next = latch_reg;
                mrm_pkg::UOP_OUT_MDR: begin
                    out_valid = 1'b1;
                    out_value = mdr_cur;
                end
                mrm_pkg::UOP_SEL_ADD:  alu_next = mrm_pkg::ALU_ADD;
                mrm_pkg::UOP_SEL_SUB:  alu_next = mrm_pkg::ALU_SUB;
                mrm_pkg::UOP_ALU:      acc_next = mrm_pkg::alu_apply(alu_reg, acc_reg, mdr_cur);
                mrm_pkg::UOP_MEM_READ: ram_re = s_accept;
                mrm_pkg::UOP_MEM_WRITE: begin
                    if (mar_reg < mrm_pkg::PROTECT_LIMIT) begin
                        status = mrm_pkg::ST_PROTECTED;
                    end else begin
                        ram_we = s_accept && wr_in_range;
                    end
                end
                mrm_pkg::UOP_PC_INC:   pc_next = pc_reg + 8'd1;
                mrm_pkg::UOP_LATCH_IN: latch_next = in_value;
                mrm_pkg::UOP_SEL_NAND: alu_next = mrm_pkg::ALU_NAND;
                default:               status = mrm_pkg::ST_INVALID;
            endcase
        end
    end

    // register file update on each accepted beat; mdr also takes a pending read byte otherwise
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg    <= 8'h00;
            mar_reg   <= 8'h00;
            mdr_reg   <= 8'h00;
            acc_reg   <= 8'h00;
            opc_reg   <= 8'h00;
            opa_reg   <= 8'h00;
            alu_reg   <= mrm_pkg::ALU_ADD;
            latch_reg <= 8'h00;
        end else if (s_accept) begin
            pc_reg    <= pc_next;
            mar_reg   <= mar_next;
            mdr_reg   <= mdr_next;
            acc_reg   <= acc_next;
            opc_reg   <= opc_next;
            opa_reg   <= opa_next;
            alu_reg   <= alu_next;
            latch_reg <= latch_next;
        end else if (rd_pend_reg) begin
            mdr_reg   <= mdr_cur;
        end
    end

    // pending read and its valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_pend_reg <= 1'b0;
            rd_ok_reg   <= 1'b0;
        end else begin
            rd_pend_reg <= ram_re;
            if (ram_re) begin
                rd_ok_reg <= rd_in_range && mem_valid_reg[rd_idx];
            end
        end
    end

    // per-byte written flags, cleared by reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < mrm_pkg::MEM_DEPTH; i++) begin
                mem_valid_reg[i] <= 1'b0;
            end
        end else if (ram_we) begin
            mem_valid_reg[wr_idx] <= 1'b1;
        end
    end

    // main memory
    mrm_ram #(
        .WIDTH (8),
        .DEPTH (mrm_pkg::MEM_DEPTH)
    ) u_mem (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (wr_idx),
        .wdata (wr_data),
        .re    (ram_re),
        .raddr (rd_idx),
        .rdata (ram_rdata)
    );

    // output beat register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_data_reg <= {opc_next, acc_next, pc_next, out_value};
            m_user_reg <= {out_valid, status};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

### tb/microop_register_machine_tb.sv
// self-checking testbench for the micro-op register machine stream block
module microop_register_machine_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // mode codes and invalid micro-op codes used by the stimulus
    localparam logic       MODE_EXEC     = 1'b0;
    localparam logic       MODE_LOAD     = 1'b1;
    localparam logic [4:0] UOP_BAD_ZERO  = 5'd0;
    localparam logic [4:0] UOP_BAD_FIRST = 5'd18;
    localparam logic [4:0] UOP_BAD_LAST  = 5'd31;

    localparam int RESET_CYCLES   = 5;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int LIMIT_CYCLES   = 250000;
    localparam int RANDOM_PHASE   = 400;

    // one input beat and one result beat
    typedef struct packed {
        logic       mode;
        logic [4:0] micro_op;
        logic [7:0] load_address;
        logic [7:0] load_data;
        logic [7:0] in_value;
    } uop_beat_t;

    typedef struct packed {
        logic [1:0] status;
        logic       out_valid;
        logic [7:0] out_value;
        logic [7:0] pc_value;
        logic [7:0] acc_value;
        logic [7:0] opcode_value;
    } reg_snapshot_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic [0:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [2:0]  m_tuser;

    microop_register_machine dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // shadow copy of the machine state
    logic [7:0]        sh_pc    = '0;
    logic [7:0]        sh_mar   = '0;
    logic [7:0]        sh_mdr   = '0;
    logic [7:0]        sh_acc   = '0;
    logic [7:0]        sh_opc   = '0;
    logic [7:0]        sh_opa   = '0;
    logic [7:0]        sh_latch = '0;
    mrm_pkg::alu_sel_t sh_alu   = mrm_pkg::ALU_ADD;
    logic [7:0]        mem_img [0:mrm_pkg::MEM_DEPTH-1];

    uop_beat_t     uop_q[$];
    reg_snapshot_t snapshot_q[$];

    int  tx_idle_pct  = 0;
    int  rx_stall_pct = 0;
    bit  tx_busy      = 1'b0;
    uop_beat_t tx_beat = '0;
    logic rx_hold_arm = 1'b0;
    int  rx_hold_left = 0;
    int  err_count    = 0;
    int  cycle_count  = 0;

    // apply one beat to the shadow state and return the register snapshot
    function automatic reg_snapshot_t run_uop(uop_beat_t b);
        reg_snapshot_t r;
        r = '0;
        r.status = mrm_pkg::ST_OK;
        if (b.mode == MODE_LOAD) begin
            if (int'(b.load_address) < mrm_pkg::MEM_DEPTH) mem_img[b.load_address] = b.load_data;
        end else begin
            case (b.micro_op)
                mrm_pkg::UOP_MAR_PC:   sh_mar = sh_pc;
                mrm_pkg::UOP_PC_MDR: begin
                    sh_pc = sh_mdr;
                    r.status = mrm_pkg::ST_JUMP;
                end
                mrm_pkg::UOP_ACC_MDR:  sh_acc = sh_mdr;
                mrm_pkg::UOP_MDR_ACC:  sh_mdr = sh_acc;
                mrm_pkg::UOP_OPC_MDR:  sh_opc = sh_mdr;
                mrm_pkg::UOP_OPA_MDR:  sh_opa = sh_mdr;
                mrm_pkg::UOP_MAR_OPA:  sh_mar = sh_opa;
                mrm_pkg::UOP_MDR_IN:   sh_mdr = sh_latch;
                mrm_pkg::UOP_OUT_MDR: begin
                    r.out_valid = 1'b1;
                    r.out_value = sh_mdr;
                end
                mrm_pkg::UOP_SEL_ADD:  sh_alu = mrm_pkg::ALU_ADD;
                mrm_pkg::UOP_SEL_SUB:  sh_alu = mrm_pkg::ALU_SUB;
                mrm_pkg::UOP_ALU: begin
                    if (sh_alu == mrm_pkg::ALU_SUB)       sh_acc = sh_acc - sh_mdr;
                    else if (sh_alu == mrm_pkg::ALU_NAND) sh_acc = ~(sh_acc & sh_mdr);
                    else                                  sh_acc = sh_acc + sh_mdr;
                end
                mrm_pkg::UOP_MEM_READ: begin
                    sh_mdr = (int'(sh_mar) < mrm_pkg::MEM_DEPTH) ? mem_img[sh_mar] : 8'h00;
                end
                mrm_pkg::UOP_MEM_WRITE: begin
                    if (sh_mar < mrm_pkg::PROTECT_LIMIT)        r.status = mrm_pkg::ST_PROTECTED;
                    else if (int'(sh_mar) < mrm_pkg::MEM_DEPTH) mem_img[sh_mar] = sh_mdr;
                end
                mrm_pkg::UOP_PC_INC:   sh_pc = sh_pc + 8'd1;
                mrm_pkg::UOP_LATCH_IN: sh_latch = b.in_value;
                mrm_pkg::UOP_SEL_NAND: sh_alu = mrm_pkg::ALU_NAND;
                default:               r.status = mrm_pkg::ST_INVALID;
            endcase
        end
        r.pc_value     = sh_pc;
        r.acc_value    = sh_acc;
        r.opcode_value = sh_opc;
        return r;
    endfunction

    // beat builders, fields the block ignores are random
    function automatic uop_beat_t mk_exec(logic [4:0] op, logic [7:0] ival);
        uop_beat_t b;
        b.mode         = MODE_EXEC;
        b.micro_op     = op;
        b.load_address = 8'($urandom_range(0, 255));
        b.load_data    = 8'($urandom_range(0, 255));
        b.in_value     = ival;
        return b;
    endfunction

    function automatic uop_beat_t mk_load(logic [7:0] addr, logic [7:0] data);
        uop_beat_t b;
        b.mode         = MODE_LOAD;
        b.micro_op     = 5'($urandom_range(0, 31));
        b.load_address = addr;
        b.load_data    = data;
        b.in_value     = 8'($urandom_range(0, 255));
        return b;
    endfunction

    task automatic send_uop(logic [4:0] op);
        uop_q.push_back(mk_exec(op, 8'($urandom_range(0, 255))));
    endtask

    task automatic send_latch(logic [7:0] v);
        uop_q.push_back(mk_exec(mrm_pkg::UOP_LATCH_IN, v));
    endtask

    task automatic send_alu_select();
        case ($urandom_range(0, 2))
            0:       send_uop(mrm_pkg::UOP_SEL_ADD);
            1:       send_uop(mrm_pkg::UOP_SEL_SUB);
            default: send_uop(mrm_pkg::UOP_SEL_NAND);
        endcase
    endtask

    // random stimulus, mostly machine-like microsequences
    task automatic gen_random(int n);
        int start;
        int pick;
        int k;
        start = uop_q.size();
        while (uop_q.size() - start < n) begin
            pick = int'($urandom_range(0, 99));
            if (pick < 15) begin
                // program load burst
                k = int'($urandom_range(1, 4));
                repeat (k) uop_q.push_back(mk_load(8'($urandom_range(0, 255)),
                                                   8'($urandom_range(0, 255))));
            end else if (pick < 33) begin
                // opcode and operand fetch
                send_uop(mrm_pkg::UOP_MAR_PC);
                send_uop(mrm_pkg::UOP_MEM_READ);
                send_uop(mrm_pkg::UOP_OPC_MDR);
                send_uop(mrm_pkg::UOP_PC_INC);
                send_uop(mrm_pkg::UOP_MAR_PC);
                send_uop(mrm_pkg::UOP_MEM_READ);
                send_uop(mrm_pkg::UOP_OPA_MDR);
                send_uop(mrm_pkg::UOP_PC_INC);
            end else if (pick < 50) begin
                // operand read and alu
                send_uop(mrm_pkg::UOP_MAR_OPA);
                send_uop(mrm_pkg::UOP_MEM_READ);
                if ($urandom_range(0, 3) == 0) send_uop(mrm_pkg::UOP_ACC_MDR);
                send_alu_select();
                send_uop(mrm_pkg::UOP_ALU);
                if ($urandom_range(0, 1) == 0) begin
                    send_uop(mrm_pkg::UOP_MDR_ACC);
                    send_uop(mrm_pkg::UOP_MEM_WRITE);
                end
            end else if (pick < 66) begin
                // store an input byte at an input address, then read it back
                send_latch(8'($urandom_range(0, 255)));
                send_uop(mrm_pkg::UOP_MDR_IN);
                send_uop(mrm_pkg::UOP_OPA_MDR);
                send_uop(mrm_pkg::UOP_MAR_OPA);
                send_latch(8'($urandom_range(0, 255)));
                send_uop(mrm_pkg::UOP_MDR_IN);
                send_uop(mrm_pkg::UOP_MEM_WRITE);
                send_uop(mrm_pkg::UOP_MEM_READ);
                send_uop(mrm_pkg::UOP_ACC_MDR);
                send_uop(mrm_pkg::UOP_OUT_MDR);
            end else if (pick < 76) begin
                // jump
                if ($urandom_range(0, 1) == 0) begin
                    send_latch(8'($urandom_range(0, 255)));
                    send_uop(mrm_pkg::UOP_MDR_IN);
                end else begin
                    send_uop(mrm_pkg::UOP_MEM_READ);
                end
                send_uop(mrm_pkg::UOP_PC_MDR);
                send_uop(mrm_pkg::UOP_PC_INC);
            end else if (pick < 86) begin
                // output
                if ($urandom_range(0, 1) == 0) send_uop(mrm_pkg::UOP_MDR_ACC);
                else                           send_uop(mrm_pkg::UOP_MDR_IN);
                send_uop(mrm_pkg::UOP_OUT_MDR);
            end else begin
                // noise: any code, any mode
                k = int'($urandom_range(1, 3));
                repeat (k) begin
                    if ($urandom_range(0, 4) == 0)
                        uop_q.push_back(mk_load(8'($urandom_range(0, 255)),
                                                8'($urandom_range(0, 255))));
                    else
                        uop_q.push_back(mk_exec(5'($urandom_range(0, 31)),
                                                8'($urandom_range(0, 255))));
                end
            end
        end
    endtask

    // wait until everything sent has come back
    task automatic drain();
        wait (uop_q.size() == 0 && !tx_busy && snapshot_q.size() == 0);
    endtask

    task automatic check_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
        if (exp_v !== act_v) begin
            err_count++;
            $display("%0t: %s mismatch, expected %02h, got %02h", $time, name, exp_v, act_v);
        end
    endtask

    // driver: holds a beat until it is taken, predicts on acceptance
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                snapshot_q.push_back(run_uop(tx_beat));
                tx_busy = 1'b0;
            end
            if (!tx_busy && uop_q.size() != 0 &&
                int'($urandom_range(0, 99)) >= tx_idle_pct) begin
                tx_beat = uop_q.pop_front();
                tx_busy = 1'b1;
            end
            s_tvalid <= tx_busy;
            s_tdata  <= {3'b000, tx_beat.in_value, tx_beat.load_data,
                         tx_beat.load_address, tx_beat.micro_op};
            s_tuser  <= tx_beat.mode;
        end
    end

    // monitor: compares each result beat with the oldest snapshot
    always @(posedge aclk) begin
        reg_snapshot_t exp_s;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (snapshot_q.size() == 0) begin
                    err_count++;
                    $display("%0t: unexpected result beat, expected none, got %h/%h",
                             $time, m_tuser, m_tdata);
                end else begin
                    exp_s = snapshot_q.pop_front();
                    check_field("status", 8'(exp_s.status), 8'(m_tuser[1:0]));
                    check_field("out_valid", 8'(exp_s.out_valid), 8'(m_tuser[2]));
                    check_field("out_value", exp_s.out_value, m_tdata[7:0]);
                    check_field("pc_value", exp_s.pc_value, m_tdata[15:8]);
                    check_field("acc_value", exp_s.acc_value, m_tdata[23:16]);
                    check_field("opcode_value", exp_s.opcode_value, m_tdata[31:24]);
                end
            end
            m_tready <= (rx_hold_left == 0) && (int'($urandom_range(0, 99)) >= rx_stall_pct);
        end
    end

    // long receiver hold-off counter
    always @(posedge aclk) begin
        if (!aresetn)           rx_hold_left <= 0;
        else if (rx_hold_arm)   rx_hold_left <= RX_HOLD_CYCLES;
        else if (rx_hold_left != 0) rx_hold_left <= rx_hold_left - 1;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // phases
    initial begin
        for (int i = 0; i < mrm_pkg::MEM_DEPTH; i++) mem_img[i] = 8'h00;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: invalid codes, loads at the address extremes, every micro-op
        send_uop(UOP_BAD_ZERO);
        send_uop(UOP_BAD_LAST);
        send_uop(UOP_BAD_FIRST);
        uop_q.push_back(mk_load(8'h00, 8'hFF));
        uop_q.push_back(mk_load(8'hFF, 8'hA5));
        send_latch(8'hFF);
        send_uop(mrm_pkg::UOP_MDR_IN);
        send_uop(mrm_pkg::UOP_OUT_MDR);
        send_uop(mrm_pkg::UOP_OPA_MDR);
        send_uop(mrm_pkg::UOP_MAR_OPA);
        send_uop(mrm_pkg::UOP_MEM_READ);
        send_uop(mrm_pkg::UOP_ACC_MDR);
        send_uop(mrm_pkg::UOP_SEL_NAND);
        send_uop(mrm_pkg::UOP_ALU);
        send_uop(mrm_pkg::UOP_SEL_SUB);
        send_uop(mrm_pkg::UOP_ALU);
        send_uop(mrm_pkg::UOP_SEL_ADD);
        send_uop(mrm_pkg::UOP_ALU);
        send_uop(mrm_pkg::UOP_MDR_ACC);
        send_uop(mrm_pkg::UOP_MEM_WRITE);
        // protected write at address zero, then jump to 0xff and wrap
        send_uop(mrm_pkg::UOP_MAR_PC);
        send_uop(mrm_pkg::UOP_MEM_WRITE);
        send_uop(mrm_pkg::UOP_MEM_READ);
        send_uop(mrm_pkg::UOP_PC_MDR);
        send_uop(mrm_pkg::UOP_PC_INC);
        send_uop(mrm_pkg::UOP_OPC_MDR);
        uop_q.push_back(mk_load(8'h1F, 8'h00));
        drain();

        // random phases with different idling
        gen_random(RANDOM_PHASE);
        drain();
        tx_idle_pct = 78;
        gen_random(RANDOM_PHASE);
        drain();
        tx_idle_pct  = 0;
        rx_stall_pct = 78;
        gen_random(RANDOM_PHASE);
        drain();
        tx_idle_pct  = 17;
        rx_stall_pct = 17;
        gen_random(RANDOM_PHASE);
        drain();

        // receiver holds off while the sender keeps offering
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        rx_hold_arm <= 1'b1;
        @(posedge aclk);
        rx_hold_arm <= 1'b0;
        gen_random(60);
        @(posedge aclk);
        wait (rx_hold_left == 0);
        drain();

        repeat (10) @(posedge aclk);
        if (err_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
